### design/tla_pkg.sv
package tla_pkg;

    // input field widths
    localparam int KIND_W = 2;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 6;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

    // neighbor count and life rule
    localparam int              CNT_W       = 4;
    localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [CNT_W-1:0] KEEP_COUNT  = 4'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              alive_in;
    } t_item;

    typedef struct packed {
        logic       alive_out;
        logic [1:0] transition;
    } t_result;

    // one line-buffer slot: one row back and two rows back
    typedef struct packed {
        logic top;
        logic mid;
    } t_tap;

    // one column of the 3x3 window
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_column;

endpackage

### design/tla_cell.sv
module tla_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  tla_pkg::t_tap i_tap,
    output tla_pkg::t_tap o_tap
);

    tla_pkg::t_tap r_tap;

    // hand the pair on to the next cell on every stream step
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tap <= i_tap;
        end
    end

    assign o_tap = r_tap;

endmodule

### design/tla_bank.sv
module tla_bank #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [2**AW];
    logic r_rdata;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // one registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/tla_stencil.sv
module tla_stencil #(
    parameter int LINE_LEN = 66
) (
    input  logic i_clk,
    input  logic i_shift,
    input  logic i_bit,
    output logic o_next
);

    tla_pkg::t_tap    w_in  [LINE_LEN];
    tla_pkg::t_tap    w_out [LINE_LEN];
    tla_pkg::t_column w_now;
    tla_pkg::t_column r_w1;
    tla_pkg::t_column r_w2;
    logic [tla_pkg::CNT_W-1:0] w_cnt;

    // chain of line-buffer cells, last one feeds the second line back in
    for (genvar k = 0; k < LINE_LEN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_in[k].mid = i_bit;
            assign w_in[k].top = w_out[LINE_LEN-1].mid;
        end else begin : g_body
            assign w_in[k] = w_out[k-1];
        end
        tla_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_tap   (w_in[k]),
            .o_tap   (w_out[k])
        );
    end

    // newest window column: two rows back, one row back, incoming bit
    assign w_now.top = w_out[LINE_LEN-1].top;
    assign w_now.mid = w_out[LINE_LEN-1].mid;
    assign w_now.bot = i_bit;

    // older window columns
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_w1 <= w_now;
            r_w2 <= r_w1;
        end
    end

    // eight neighbors of the window center
    assign w_cnt = tla_pkg::CNT_W'(w_now.top) + tla_pkg::CNT_W'(w_now.mid)
                 + tla_pkg::CNT_W'(w_now.bot) + tla_pkg::CNT_W'(r_w1.top)
                 + tla_pkg::CNT_W'(r_w1.bot)  + tla_pkg::CNT_W'(r_w2.top)
                 + tla_pkg::CNT_W'(r_w2.mid)  + tla_pkg::CNT_W'(r_w2.bot);

    // b3/s23 rule
    assign o_next = (w_cnt == tla_pkg::BIRTH_COUNT)
                  | ((w_cnt == tla_pkg::KEEP_COUNT) & r_w1.mid);

endmodule

### design/toroidal_life_automaton.sv
// Toroidal life grid, rule B3/S23, GRID_COLS x GRID_ROWS one-bit cells.
// Command channel: an item transfers at a clock edge with start high and busy
// low. Kinds: write cell, read cell, advance one generation, clear grid.
// Result channel: o_done is high for one cycle with o_result holding the
// addressed cell's state and its transition class after the operation.
// Every item gives exactly one result; the receiver cannot stall, so the
// result must be taken in that cycle.
// Order of work after a transfer: col and row are first reduced modulo the
// grid size by one subtract per cycle (no subtract for the default 64x64).
// Then read and write go on to a registered bank read, clear zeroes every
// address of both banks, and advance sweeps the grid with one wrapped cell
// on each side: the sweep reads one cell per cycle from the live bank
// through a chain of line-buffer cells and writes the new generation into
// the other bank, which then becomes live.
// One item is in work at a time; busy is high from transfer until o_done.
// Reset (synchronous, active low) starts a clearing pass over both banks,
// with busy high; no result is given for it.
module toroidal_life_automaton #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tla_pkg::t_item    i_item,
    output logic              busy,
    output logic              o_done,
    output tla_pkg::t_result  o_result
);

    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int AW = CW + RW;
    localparam int CX = (CW > tla_pkg::COL_W) ? CW : tla_pkg::COL_W;
    localparam int RX = (RW > tla_pkg::ROW_W) ? RW : tla_pkg::ROW_W;
    localparam int IW = $clog2(GRID_COLS + 2);
    localparam int JW = $clog2(GRID_ROWS + 2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_RESP  = 3'd6;

    logic [2:0]                r_state, n_state;
    logic                      r_boot, n_boot;
    logic                      r_sel, n_sel;
    logic [tla_pkg::KIND_W-1:0] r_kind, n_kind;
    logic                      r_alive_in, n_alive_in;
    logic [CX-1:0]             r_col, n_col;
    logic [RX-1:0]             r_row, n_row;
    logic [AW-1:0]             r_clr, n_clr;
    logic [IW-1:0]             r_i, n_i, r_i1;
    logic [JW-1:0]             r_j, n_j, r_j1;
    logic                      r_sv, n_sv;
    logic                      r_done, n_done;
    tla_pkg::t_result          r_result, n_result;

    logic          w_col_hi;
    logic          w_row_hi;
    logic          w_dispatch;
    logic          w_sweep_last;
    logic [CW-1:0] w_rd_col;
    logic [RW-1:0] w_rd_row;
    logic [AW-1:0] w_cell_addr;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_st_addr;
    logic          w_st_we;
    logic          w_st_next;
    logic          w_cur_rd;
    logic          w_pri_rd;
    logic          w_rdata [2];
    logic          w_we    [2];
    logic [AW-1:0] w_waddr [2];
    logic          w_wdata [2];

    // address reduction and decode
    assign w_col_hi   = (CX+1)'(r_col) >= (CX+1)'(GRID_COLS);
    assign w_row_hi   = (RX+1)'(r_row) >= (RX+1)'(GRID_ROWS);
    assign w_dispatch = (r_state == ST_MOD) && !w_col_hi && !w_row_hi;
    assign w_cell_addr = {r_row[RW-1:0], r_col[CW-1:0]};

    // sweep stream: each row and column is read with one wrapped cell on each side
    always_comb begin
        if (r_i == '0) begin
            w_rd_col = CW'(GRID_COLS - 1);
        end else if (r_i == IW'(GRID_COLS + 1)) begin
            w_rd_col = '0;
        end else begin
            w_rd_col = CW'(r_i - IW'(1));
        end
        if (r_j == '0) begin
            w_rd_row = RW'(GRID_ROWS - 1);
        end else if (r_j == JW'(GRID_ROWS + 1)) begin
            w_rd_row = '0;
        end else begin
            w_rd_row = RW'(r_j - JW'(1));
        end
    end

    assign w_sweep_last = (r_i == IW'(GRID_COLS + 1)) && (r_j == JW'(GRID_ROWS + 1));
    assign w_raddr = (r_state == ST_SWEEP) ? {w_rd_row, w_rd_col} : w_cell_addr;

    // window center lies one row and one column behind the incoming bit
    assign w_st_we   = r_sv && (r_i1 >= IW'(2)) && (r_j1 >= JW'(2));
    assign w_st_addr = {RW'(r_j1 - JW'(2)), CW'(r_i1 - IW'(2))};

    // live bank and prior bank read data
    assign w_cur_rd = r_sel ? w_rdata[1] : w_rdata[0];
    assign w_pri_rd = r_sel ? w_rdata[0] : w_rdata[1];

    // bank write ports
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            w_we[b]    = 1'b0;
            w_waddr[b] = w_cell_addr;
            w_wdata[b] = 1'b0;
        end
        if (r_state == ST_CLEAR) begin
            for (int b = 0; b < 2; b++) begin
                w_we[b]    = 1'b1;
                w_waddr[b] = r_clr;
            end
        end else if (w_dispatch && (r_kind == tla_pkg::KIND_WRITE)) begin
            w_we[r_sel]    = 1'b1;
            w_wdata[r_sel] = r_alive_in;
        end else if (w_st_we) begin
            w_we[!r_sel]    = 1'b1;
            w_waddr[!r_sel] = w_st_addr;
            w_wdata[!r_sel] = w_st_next;
        end
    end

    // control sequencer
    always_comb begin
        n_state    = r_state;
        n_boot     = r_boot;
        n_sel      = r_sel;
        n_kind     = r_kind;
        n_alive_in = r_alive_in;
        n_col      = r_col;
        n_row      = r_row;
        n_clr      = r_clr;
        n_i        = r_i;
        n_j        = r_j;
        n_sv       = (r_state == ST_SWEEP);
        n_done     = 1'b0;
        n_result   = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_kind     = i_item.kind;
                    n_col      = CX'(i_item.col);
                    n_row      = RX'(i_item.row);
                    n_alive_in = i_item.alive_in;
                    n_state    = ST_MOD;
                end
            end
            ST_MOD: begin
                if (w_col_hi) begin
                    n_col = r_col - CX'(GRID_COLS);
                end
                if (w_row_hi) begin
                    n_row = r_row - RX'(GRID_ROWS);
                end
                if (w_dispatch) begin
                    unique case (r_kind)
                        tla_pkg::KIND_WRITE: begin
                            n_state = ST_READ;
                        end
                        tla_pkg::KIND_READ: begin
                            n_state = ST_READ;
                        end
                        tla_pkg::KIND_ADVANCE: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_state = ST_SWEEP;
                        end
                        tla_pkg::KIND_CLEAR: begin
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_READ;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? ST_IDLE : ST_READ;
                end
            end
            ST_SWEEP: begin
                if (w_sweep_last) begin
                    n_state = ST_DRAIN;
                end else if (r_i == IW'(GRID_COLS + 1)) begin
                    n_i = '0;
                    n_j = r_j + JW'(1);
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            ST_DRAIN: begin
                n_sel   = !r_sel;
                n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                n_result.alive_out  = w_cur_rd;
                n_result.transition = {w_pri_rd, w_cur_rd};
                n_done              = 1'b1;
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_boot  <= 1'b1;
            r_sel   <= 1'b0;
            r_clr   <= '0;
            r_sv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
            r_sel   <= n_sel;
            r_clr   <= n_clr;
            r_sv    <= n_sv;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_alive_in <= n_alive_in;
        r_col      <= n_col;
        r_row      <= n_row;
        r_i        <= n_i;
        r_j        <= n_j;
        r_i1       <= r_i;
        r_j1       <= r_j;
        r_result   <= n_result;
    end

    // two grid banks: one live, the other holds the prior generation
    for (genvar b = 0; b < 2; b++) begin : g_bank
        tla_bank #(
            .AW (AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_waddr (w_waddr[b]),
            .i_wdata (w_wdata[b]),
            .i_raddr (w_raddr),
            .o_rdata (w_rdata[b])
        );
    end

    // neighborhood window over the read stream
    tla_stencil #(
        .LINE_LEN (GRID_COLS + 2)
    ) u_stencil (
        .i_clk   (i_clk),
        .i_shift (r_sv),
        .i_bit   (w_cur_rd),
        .o_next  (w_st_next)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // bank roles swap only at the end of a sweep
    a_sel_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_sel) |-> $past(r_state) == ST_DRAIN)
        else $error("bank select changed outside sweep end");

    // stencil stage runs only inside a sweep
    a_stencil_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> (r_state == ST_SWEEP || r_state == ST_DRAIN))
        else $error("stencil stage active outside sweep");

    // a cleared grid reports a dead cell that stayed dead
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_kind == tla_pkg::KIND_CLEAR) |-> (o_result == '0))
        else $error("clear returned a nonzero result");

    // one result per item, never on consecutive cycles
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

endmodule
